### rtl/oapi_pkg.sv
// shared types, constants and helpers for the open-addressing probe/insert block
`default_nettype none
package oapi_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 64;
    localparam int unsigned KEY_W   = 31;
    localparam int unsigned SIZE_W  = 7;
    localparam int unsigned COEF_W  = 8;
    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned STEP_W  = 7;
    localparam int unsigned TOT_W   = 32;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned DCNT_W  = 5;

    // divider step counts: full key, or one coefficient loaded at the top
    localparam logic [DCNT_W-1:0] DIV_KEY_STEPS  = 5'd31;
    localparam logic [DCNT_W-1:0] DIV_COEF_STEPS = 5'd8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
    localparam logic [COEF_W-1:0] QLIN_RESET = 8'd1;
    localparam logic [COEF_W-1:0] QSQ_RESET  = 8'd3;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SLOT_COUNT = 2'd0,
        CFG_QUAD_LIN   = 2'd1,
        CFG_QUAD_SQ    = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_READ   = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        DIV_KEY = 2'd0,
        DIV_C1  = 2'd1,
        DIV_C2  = 2'd2
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEY_GO,
        S_KEY_WAIT,
        S_C1_GO,
        S_C1_WAIT,
        S_C2_GO,
        S_C2_WAIT,
        S_SETUP,
        S_PROBE,
        S_INS_OUT,
        S_RD_ISSUE,
        S_RD_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap_rem;
        logic     setup;
        logic     probe;
        logic     fin_ins;
        logic     rd_issue;
        logic     fin_rd;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic probe_fin;
    } t_dp_stat;

    // sum of two residues, folded back once below the modulus
    function automatic logic [SIZE_W-1:0] f_mod_add(input logic [SIZE_W-1:0] a,
                                                    input logic [SIZE_W-1:0] b,
                                                    input logic [SIZE_W-1:0] m);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[SIZE_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/oapi_div.sv
// restoring remainder unit, one dividend bit per cycle
`default_nettype none
module oapi_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [oapi_pkg::KEY_W-1:0]         i_dividend,
    input  wire logic [oapi_pkg::DCNT_W-1:0]        i_steps,
    input  wire logic [oapi_pkg::SIZE_W-1:0]        i_divisor,
    output logic                                    o_done,
    output logic [oapi_pkg::SIZE_W-1:0]             o_rem
);
    logic [oapi_pkg::KEY_W-1:0]  r_q;
    logic [oapi_pkg::SIZE_W-1:0] r_r, n_r;
    logic [oapi_pkg::DCNT_W-1:0] r_cnt;
    logic                        r_done;
    logic [oapi_pkg::SIZE_W:0]   trial;

    // shift in the next dividend bit and subtract when it fits
    always_comb begin
        trial = {r_r, r_q[oapi_pkg::KEY_W-1]};
        if (trial >= {1'b0, i_divisor}) begin
            trial = trial - {1'b0, i_divisor};
        end
        n_r = trial[oapi_pkg::SIZE_W-1:0];
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= i_steps;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == 5'd1);
            end
        end
    end

    // partial remainder and dividend shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
        end else if (r_cnt != '0) begin
            r_q <= {r_q[oapi_pkg::KEY_W-2:0], 1'b0};
            r_r <= n_r;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_r;

endmodule
`default_nettype wire

### rtl/oapi_dp.sv
// datapath: configuration, key memories, occupancy bits, probe logic, result words
`default_nettype none
module oapi_dp #(
    parameter int unsigned TABLE_DEPTH = oapi_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire oapi_pkg::t_dp_ctl             i_ctl,
    output oapi_pkg::t_dp_stat                 o_stat,
    input  wire logic                          i_cfg_we,
    input  wire logic [oapi_pkg::CIDX_W-1:0]   i_cfg_index,
    input  wire logic [oapi_pkg::COEF_W-1:0]   i_cfg_data,
    input  wire logic [oapi_pkg::KEY_W-1:0]    i_key,
    input  wire logic [oapi_pkg::SLOT_W-1:0]   i_slot_index,
    output logic                               o_strobe,
    output logic [oapi_pkg::SLOT_W-1:0]        o_linear_slot,
    output logic                               o_linear_placed,
    output logic [oapi_pkg::STEP_W-1:0]        o_linear_step_collisions,
    output logic [oapi_pkg::SLOT_W-1:0]        o_quad_slot,
    output logic                               o_quad_placed,
    output logic [oapi_pkg::STEP_W-1:0]        o_quad_step_collisions,
    output logic [oapi_pkg::TOT_W-1:0]         o_linear_total_collisions,
    output logic [oapi_pkg::TOT_W-1:0]         o_quad_total_collisions,
    output logic [oapi_pkg::KEY_W-1:0]         o_read_linear_key,
    output logic                               o_read_linear_used,
    output logic [oapi_pkg::KEY_W-1:0]         o_read_quad_key,
    output logic                               o_read_quad_used
);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned SW = oapi_pkg::SIZE_W;

    // configuration registers
    logic [SW-1:0]                   r_size;
    logic [oapi_pkg::COEF_W-1:0]     r_c1, r_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= oapi_pkg::SIZE_RESET;
            r_c1   <= oapi_pkg::QLIN_RESET;
            r_c2   <= oapi_pkg::QSQ_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == oapi_pkg::CFG_SLOT_COUNT) begin
                r_size <= i_cfg_data[SW-1:0];
            end
            if (i_cfg_index == oapi_pkg::CFG_QUAD_LIN) begin
                r_c1 <= i_cfg_data;
            end
            if (i_cfg_index == oapi_pkg::CFG_QUAD_SQ) begin
                r_c2 <= i_cfg_data;
            end
        end
    end

    // active size, clamped to one and to the table depth
    logic [SW-1:0] act_size;
    always_comb begin
        if (r_size == '0) begin
            act_size = 7'd1;
        end else if (int'(r_size) > int'(TABLE_DEPTH)) begin
            act_size = SW'(TABLE_DEPTH);
        end else begin
            act_size = r_size;
        end
    end

    // word latched at accept
    logic [oapi_pkg::KEY_W-1:0]  r_key;
    logic [oapi_pkg::SLOT_W-1:0] r_idx;
    logic [SW-1:0]               r_m;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key <= i_key;
            r_idx <= i_slot_index;
            r_m   <= act_size;
        end
    end

    // shared remainder unit
    logic [oapi_pkg::KEY_W-1:0]  div_dividend;
    logic [oapi_pkg::DCNT_W-1:0] div_steps;
    logic                        div_done;
    logic [SW-1:0]               div_rem;

    always_comb begin
        unique case (i_ctl.div_sel)
            oapi_pkg::DIV_C1: begin
                div_dividend = {r_c1, 23'd0};
                div_steps    = oapi_pkg::DIV_COEF_STEPS;
            end
            oapi_pkg::DIV_C2: begin
                div_dividend = {r_c2, 23'd0};
                div_steps    = oapi_pkg::DIV_COEF_STEPS;
            end
            default: begin
                div_dividend = r_key;
                div_steps    = oapi_pkg::DIV_KEY_STEPS;
            end
        endcase
    end

    oapi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (div_dividend),
        .i_steps    (div_steps),
        .i_divisor  (r_m),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // residues of key and coefficients
    logic [SW-1:0] r_home, r_c1m, r_c2m;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_rem) begin
            unique case (i_ctl.div_sel)
                oapi_pkg::DIV_C1: r_c1m  <= div_rem;
                oapi_pkg::DIV_C2: r_c2m  <= div_rem;
                default:          r_home <= div_rem;
            endcase
        end
    end

    // probe state
    logic [SW-1:0]    r_i, r_lpos, r_qpos, r_qd, r_qe, r_lcoll, r_qcoll;
    logic             r_ldone, r_qdone;
    logic [SW-1:0]    lpos_inc;
    logic             l_occ, q_occ, l_wr, q_wr;
    logic [TABLE_DEPTH-1:0] r_lused, r_qused;

    assign l_occ = r_lused[AW'(r_lpos)];
    assign q_occ = r_qused[AW'(r_qpos)];
    assign l_wr  = i_ctl.probe && !r_ldone && !l_occ;
    assign q_wr  = i_ctl.probe && !r_qdone && !q_occ;
    assign lpos_inc = (r_lpos + 1'b1 == r_m) ? '0 : r_lpos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.setup) begin
            r_i     <= '0;
            r_lpos  <= r_home;
            r_qpos  <= r_home;
            r_qd    <= oapi_pkg::f_mod_add(r_c1m, r_c2m, r_m);
            r_qe    <= oapi_pkg::f_mod_add(r_c2m, r_c2m, r_m);
            r_ldone <= 1'b0;
            r_qdone <= 1'b0;
        end else if (i_ctl.probe) begin
            r_i <= r_i + 1'b1;
            // linear table: next slot with wrap
            if (!r_ldone) begin
                if (!l_occ) begin
                    r_ldone <= 1'b1;
                    r_lcoll <= r_i;
                end else begin
                    r_lpos <= lpos_inc;
                end
            end
            // quadratic table: offset grows by a running difference
            if (!r_qdone) begin
                if (!q_occ) begin
                    r_qdone <= 1'b1;
                    r_qcoll <= r_i;
                end else begin
                    r_qpos <= oapi_pkg::f_mod_add(r_qpos, r_qd, r_m);
                    r_qd   <= oapi_pkg::f_mod_add(r_qd, r_qe, r_m);
                end
            end
        end
    end

    // occupancy bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lused <= '0;
            r_qused <= '0;
        end else begin
            if (l_wr) begin
                r_lused[AW'(r_lpos)] <= 1'b1;
            end
            if (q_wr) begin
                r_qused[AW'(r_qpos)] <= 1'b1;
            end
        end
    end

    // key memories, one write and one registered read each
    logic [oapi_pkg::KEY_W-1:0] lmem [TABLE_DEPTH];
    logic [oapi_pkg::KEY_W-1:0] qmem [TABLE_DEPTH];
    logic [oapi_pkg::KEY_W-1:0] r_lrd, r_qrd;
    logic                       r_lrd_used, r_qrd_used, r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (l_wr) begin
            lmem[AW'(r_lpos)] <= r_key;
        end
        if (q_wr) begin
            qmem[AW'(r_qpos)] <= r_key;
        end
        if (i_ctl.rd_issue) begin
            r_lrd      <= lmem[AW'(r_idx)];
            r_qrd      <= qmem[AW'(r_idx)];
            r_lrd_used <= r_lused[AW'(r_idx)];
            r_qrd_used <= r_qused[AW'(r_idx)];
            r_rd_ok    <= int'(r_idx) < int'(TABLE_DEPTH);
        end
    end

    // step results and saturating totals
    logic [SW-1:0]                 lcoll_res, qcoll_res;
    logic [oapi_pkg::TOT_W:0]      lsum, qsum;
    logic [oapi_pkg::TOT_W-1:0]    r_ltot, r_qtot, ltot_new, qtot_new;

    assign lcoll_res = r_ldone ? r_lcoll : r_i;
    assign qcoll_res = r_qdone ? r_qcoll : r_i;
    assign lsum = {1'b0, r_ltot} + {{(oapi_pkg::TOT_W+1-SW){1'b0}}, lcoll_res};
    assign qsum = {1'b0, r_qtot} + {{(oapi_pkg::TOT_W+1-SW){1'b0}}, qcoll_res};
    assign ltot_new = lsum[oapi_pkg::TOT_W] ? '1 : lsum[oapi_pkg::TOT_W-1:0];
    assign qtot_new = qsum[oapi_pkg::TOT_W] ? '1 : qsum[oapi_pkg::TOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ltot <= '0;
            r_qtot <= '0;
        end else if (i_ctl.fin_ins) begin
            r_ltot <= ltot_new;
            r_qtot <= qtot_new;
        end
    end

    // result word register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_ctl.fin_ins || i_ctl.fin_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fin_ins) begin
            o_linear_slot             <= r_ldone ? oapi_pkg::SLOT_W'(r_lpos) : '0;
            o_linear_placed           <= r_ldone;
            o_linear_step_collisions  <= lcoll_res;
            o_quad_slot               <= r_qdone ? oapi_pkg::SLOT_W'(r_qpos) : '0;
            o_quad_placed             <= r_qdone;
            o_quad_step_collisions    <= qcoll_res;
            o_linear_total_collisions <= ltot_new;
            o_quad_total_collisions   <= qtot_new;
            o_read_linear_key         <= '0;
            o_read_linear_used        <= 1'b0;
            o_read_quad_key           <= '0;
            o_read_quad_used          <= 1'b0;
        end else if (i_ctl.fin_rd) begin
            o_linear_slot             <= '0;
            o_linear_placed           <= 1'b0;
            o_linear_step_collisions  <= '0;
            o_quad_slot               <= '0;
            o_quad_placed             <= 1'b0;
            o_quad_step_collisions    <= '0;
            o_linear_total_collisions <= r_ltot;
            o_quad_total_collisions   <= r_qtot;
            o_read_linear_key         <= (r_rd_ok && r_lrd_used) ? r_lrd : '0;
            o_read_linear_used        <= r_rd_ok && r_lrd_used;
            o_read_quad_key           <= (r_rd_ok && r_qrd_used) ? r_qrd : '0;
            o_read_quad_used          <= r_rd_ok && r_qrd_used;
        end
    end

    // status back to the controller
    assign o_stat.div_done  = div_done;
    assign o_stat.probe_fin = (r_ldone && r_qdone) || (r_i == r_m);

`ifndef SYNTHESIS
    // probe count never runs past the active size
    a_i_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.probe |-> (r_i < r_m))
        else $error("probe count past active size");
    // probe positions stay inside the active size
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.probe |-> (r_lpos < r_m) && (r_qpos < r_m))
        else $error("probe position out of range");
    // a linear slot that takes a key is marked occupied afterwards
    a_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        l_wr |=> r_lused[AW'($past(r_lpos))])
        else $error("linear slot not marked after write");
`endif

endmodule
`default_nettype wire

### rtl/oapi_ctrl.sv
// controller: sequences remainders, probing and result delivery
`default_nettype none
module oapi_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_is_read,
    input  wire oapi_pkg::t_dp_stat    i_stat,
    output oapi_pkg::t_dp_ctl          o_ctl,
    output logic                       o_busy
);
    oapi_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oapi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.div_sel = oapi_pkg::DIV_KEY;
        unique case (r_state)
            oapi_pkg::S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state = i_is_read ? oapi_pkg::S_RD_ISSUE : oapi_pkg::S_KEY_GO;
                end
            end
            oapi_pkg::S_KEY_GO: begin
                o_ctl.div_start = 1'b1;
                n_state = oapi_pkg::S_KEY_WAIT;
            end
            oapi_pkg::S_KEY_WAIT: begin
                if (i_stat.div_done) begin
                    o_ctl.cap_rem = 1'b1;
                    n_state = oapi_pkg::S_C1_GO;
                end
            end
            oapi_pkg::S_C1_GO: begin
                o_ctl.div_sel   = oapi_pkg::DIV_C1;
                o_ctl.div_start = 1'b1;
                n_state = oapi_pkg::S_C1_WAIT;
            end
            oapi_pkg::S_C1_WAIT: begin
                o_ctl.div_sel = oapi_pkg::DIV_C1;
                if (i_stat.div_done) begin
                    o_ctl.cap_rem = 1'b1;
                    n_state = oapi_pkg::S_C2_GO;
                end
            end
            oapi_pkg::S_C2_GO: begin
                o_ctl.div_sel   = oapi_pkg::DIV_C2;
                o_ctl.div_start = 1'b1;
                n_state = oapi_pkg::S_C2_WAIT;
            end
            oapi_pkg::S_C2_WAIT: begin
                o_ctl.div_sel = oapi_pkg::DIV_C2;
                if (i_stat.div_done) begin
                    o_ctl.cap_rem = 1'b1;
                    n_state = oapi_pkg::S_SETUP;
                end
            end
            oapi_pkg::S_SETUP: begin
                o_ctl.setup = 1'b1;
                n_state = oapi_pkg::S_PROBE;
            end
            oapi_pkg::S_PROBE: begin
                if (i_stat.probe_fin) begin
                    n_state = oapi_pkg::S_INS_OUT;
                end else begin
                    o_ctl.probe = 1'b1;
                end
            end
            oapi_pkg::S_INS_OUT: begin
                o_ctl.fin_ins = 1'b1;
                n_state = oapi_pkg::S_IDLE;
            end
            oapi_pkg::S_RD_ISSUE: begin
                o_ctl.rd_issue = 1'b1;
                n_state = oapi_pkg::S_RD_OUT;
            end
            oapi_pkg::S_RD_OUT: begin
                o_ctl.fin_rd = 1'b1;
                n_state = oapi_pkg::S_IDLE;
            end
            default: begin
                n_state = oapi_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != oapi_pkg::S_IDLE);

`ifndef SYNTHESIS
    // a finished word always returns to idle
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.fin_ins || o_ctl.fin_rd) |=> (r_state == oapi_pkg::S_IDLE))
        else $error("no return to idle after result");
    // never probe and finish in the same cycle
    a_probe_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.probe |-> !o_ctl.fin_ins && !o_ctl.fin_rd)
        else $error("probe overlaps finish");
    // a word is only taken when idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |-> !o_busy)
        else $error("word taken while busy");
`endif

endmodule
`default_nettype wire

### rtl/open_addressing_probe_insert.sv
// top level: linear and quadratic open-addressing insert and read-back
//
//  channel   | handshake                      | contents
//  ----------+--------------------------------+-----------------------------------
//  command   | start / busy                   | i_command, i_key, i_slot_index
//  result    | o_strobe (one cycle, no stall) | slot, placed, collisions, totals, read
//  config    | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// insert: the key remainder, then the two coefficient residues, one setup step, then the probe
// walk (both tables together, at most m probes, m being the active size), an end-of-walk step
// and the result step. a read issues the memory read and then delivers the result.
// the remainder unit (one bit a cycle) and the probe walk set the insert time.
// reset is synchronous, active low; it empties both tables and clears the totals.
// results are never held off; o_strobe marks each for one cycle.
`default_nettype none
module open_addressing_probe_insert #(
    parameter int unsigned TABLE_DEPTH = oapi_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_command,
    input  wire logic [oapi_pkg::KEY_W-1:0]    i_key,
    input  wire logic [oapi_pkg::SLOT_W-1:0]   i_slot_index,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [oapi_pkg::CIDX_W-1:0]   i_cfg_index,
    input  wire logic [oapi_pkg::COEF_W-1:0]   i_cfg_data,
    output logic                               o_strobe,
    output logic [oapi_pkg::SLOT_W-1:0]        o_linear_slot,
    output logic                               o_linear_placed,
    output logic [oapi_pkg::STEP_W-1:0]        o_linear_step_collisions,
    output logic [oapi_pkg::SLOT_W-1:0]        o_quad_slot,
    output logic                               o_quad_placed,
    output logic [oapi_pkg::STEP_W-1:0]        o_quad_step_collisions,
    output logic [oapi_pkg::TOT_W-1:0]         o_linear_total_collisions,
    output logic [oapi_pkg::TOT_W-1:0]         o_quad_total_collisions,
    output logic [oapi_pkg::KEY_W-1:0]         o_read_linear_key,
    output logic                               o_read_linear_used,
    output logic [oapi_pkg::KEY_W-1:0]         o_read_quad_key,
    output logic                               o_read_quad_used
);
    oapi_pkg::t_dp_ctl  ctl;
    oapi_pkg::t_dp_stat stat;

    // configuration words are always taken
    assign o_cfg_ready = 1'b1;

    oapi_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_is_read (i_command == oapi_pkg::CMD_READ),
        .i_stat    (stat),
        .o_ctl     (ctl),
        .o_busy    (busy)
    );

    oapi_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_ctl                     (ctl),
        .o_stat                    (stat),
        .i_cfg_we                  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index               (i_cfg_index),
        .i_cfg_data                (i_cfg_data),
        .i_key                     (i_key),
        .i_slot_index              (i_slot_index),
        .o_strobe                  (o_strobe),
        .o_linear_slot             (o_linear_slot),
        .o_linear_placed           (o_linear_placed),
        .o_linear_step_collisions  (o_linear_step_collisions),
        .o_quad_slot               (o_quad_slot),
        .o_quad_placed             (o_quad_placed),
        .o_quad_step_collisions    (o_quad_step_collisions),
        .o_linear_total_collisions (o_linear_total_collisions),
        .o_quad_total_collisions   (o_quad_total_collisions),
        .o_read_linear_key         (o_read_linear_key),
        .o_read_linear_used        (o_read_linear_used),
        .o_read_quad_key           (o_read_quad_key),
        .o_read_quad_used          (o_read_quad_used)
    );

endmodule
`default_nettype wire

### tb/sv/tb.sv
// self-checking testbench for the open-addressing probe/insert block
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;

    // one result word as seen on the ports
    typedef struct packed {
        logic [5:0]  lslot;
        logic        lplaced;
        logic [6:0]  lstep;
        logic [5:0]  qslot;
        logic        qplaced;
        logic [6:0]  qstep;
        logic [31:0] ltot;
        logic [31:0] qtot;
        logic [30:0] rlkey;
        logic        rlused;
        logic [30:0] rqkey;
        logic        rqused;
    } t_res;

    // one directed stimulus row; chk set where the result is typed in
    typedef struct {
        oapi_pkg::t_cmd cmd;
        logic [30:0]    key;
        logic [5:0]     idx;
        bit             chk;
        t_res           res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_command = 1'b0;
    logic [30:0] i_key = '0;
    logic [5:0]  i_slot_index = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        o_strobe;
    t_res        dut_res;

    always #5 i_clk = ~i_clk;

    open_addressing_probe_insert u_top (
        .i_clk, .i_rst_n, .start, .busy, .i_command, .i_key, .i_slot_index,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data, .o_strobe,
        .o_linear_slot(dut_res.lslot), .o_linear_placed(dut_res.lplaced),
        .o_linear_step_collisions(dut_res.lstep),
        .o_quad_slot(dut_res.qslot), .o_quad_placed(dut_res.qplaced),
        .o_quad_step_collisions(dut_res.qstep),
        .o_linear_total_collisions(dut_res.ltot),
        .o_quad_total_collisions(dut_res.qtot),
        .o_read_linear_key(dut_res.rlkey), .o_read_linear_used(dut_res.rlused),
        .o_read_quad_key(dut_res.rqkey), .o_read_quad_used(dut_res.rqused)
    );

    // shadow table state
    logic [30:0] lin_key_q [DEPTH];
    logic        lin_used_q [DEPTH];
    logic [30:0] quad_key_q [DEPTH];
    logic        quad_used_q [DEPTH];
    logic [31:0] lin_total, quad_total;
    logic [6:0]  size_reg;
    logic [7:0]  c1_reg, c2_reg;

    t_res        pending_res [$];
    int          n_err = 0;
    int          n_res = 0;
    int          n_ins = 0;
    int          n_full = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        n_err++;
    endtask

    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // insert into one shadow table, returns placed, slot and passed count
    function automatic void probe_table(input bit quad, input logic [30:0] key,
                                        output logic placed, output logic [5:0] slot,
                                        output int passed);
        int unsigned m, home, s;
        longint unsigned pos;
        m = (size_reg == 0) ? 1 : (size_reg > DEPTH) ? DEPTH : size_reg;
        home = key % m;
        placed = 1'b0;
        slot = '0;
        passed = 0;
        for (int unsigned i = 0; i < m; i++) begin
            pos = quad ? longint'(home) + longint'(c1_reg) * i + longint'(c2_reg) * i * i
                       : longint'(home) + i;
            s = 32'(pos % m);
            if (quad ? !quad_used_q[s] : !lin_used_q[s]) begin
                if (quad) begin
                    quad_used_q[s] = 1'b1;
                    quad_key_q[s] = key;
                end else begin
                    lin_used_q[s] = 1'b1;
                    lin_key_q[s] = key;
                end
                placed = 1'b1;
                slot = s[5:0];
                return;
            end
            passed++;
        end
    endfunction

    function automatic t_res predict_probe(input oapi_pkg::t_cmd cmd, input logic [30:0] key,
                                           input logic [5:0] idx);
        t_res r;
        int lc, qc;
        r = '0;
        if (cmd == oapi_pkg::CMD_INSERT) begin
            probe_table(1'b0, key, r.lplaced, r.lslot, lc);
            probe_table(1'b1, key, r.qplaced, r.qslot, qc);
            lin_total = sat_sum(lin_total, 32'(lc));
            quad_total = sat_sum(quad_total, 32'(qc));
            r.lstep = (lc > 127) ? 7'd127 : lc[6:0];
            r.qstep = (qc > 127) ? 7'd127 : qc[6:0];
        end else begin
            r.rlused = lin_used_q[idx];
            r.rlkey = lin_used_q[idx] ? lin_key_q[idx] : '0;
            r.rqused = quad_used_q[idx];
            r.rqkey = quad_used_q[idx] ? quad_key_q[idx] : '0;
        end
        r.ltot = lin_total;
        r.qtot = quad_total;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && o_strobe) begin
            n_res++;
            if (pending_res.size() == 0) begin
                report_mismatch("unexpected word", '0, '0);
            end else begin
                w = pending_res.pop_front();
                if (dut_res.lslot !== w.lslot)
                    report_mismatch("linear_slot", 32'(dut_res.lslot), 32'(w.lslot));
                if (dut_res.lplaced !== w.lplaced)
                    report_mismatch("linear_placed", 32'(dut_res.lplaced), 32'(w.lplaced));
                if (dut_res.lstep !== w.lstep)
                    report_mismatch("linear_step", 32'(dut_res.lstep), 32'(w.lstep));
                if (dut_res.qslot !== w.qslot)
                    report_mismatch("quad_slot", 32'(dut_res.qslot), 32'(w.qslot));
                if (dut_res.qplaced !== w.qplaced)
                    report_mismatch("quad_placed", 32'(dut_res.qplaced), 32'(w.qplaced));
                if (dut_res.qstep !== w.qstep)
                    report_mismatch("quad_step", 32'(dut_res.qstep), 32'(w.qstep));
                if (dut_res.ltot !== w.ltot)
                    report_mismatch("linear_total", dut_res.ltot, w.ltot);
                if (dut_res.qtot !== w.qtot)
                    report_mismatch("quad_total", dut_res.qtot, w.qtot);
                if (dut_res.rlkey !== w.rlkey)
                    report_mismatch("read_linear_key", 32'(dut_res.rlkey), 32'(w.rlkey));
                if (dut_res.rlused !== w.rlused)
                    report_mismatch("read_linear_used", 32'(dut_res.rlused), 32'(w.rlused));
                if (dut_res.rqkey !== w.rqkey)
                    report_mismatch("read_quad_key", 32'(dut_res.rqkey), 32'(w.rqkey));
                if (dut_res.rqused !== w.rqused)
                    report_mismatch("read_quad_used", 32'(dut_res.rqused), 32'(w.rqused));
            end
        end
    end

    // random gap, mostly short, a few long; start is low for at least one edge
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        repeat (n + 1) @(posedge i_clk);
    endtask

    // issue one command word and record its expected result
    task automatic send_word(input oapi_pkg::t_cmd cmd, input logic [30:0] key,
                             input logic [5:0] idx, input bit chk, input t_res typed);
        t_res p;
        start <= 1'b1;
        i_command <= cmd;
        i_key <= key;
        i_slot_index <= idx;
        do @(posedge i_clk); while (busy);
        p = predict_probe(cmd, key, idx);
        if (chk && p !== typed) report_mismatch("typed row vs predictor", '0, '0);
        pending_res.push_back(chk ? typed : p);
        if (cmd == oapi_pkg::CMD_INSERT) begin
            n_ins++;
            if (!p.lplaced || !p.qplaced) n_full++;
        end
        start <= 1'b0;
        idle_gap();
    endtask

    // wait for all results, then some settling cycles
    task automatic drain();
        int guard;
        guard = 0;
        while (pending_res.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_reg(input oapi_pkg::t_cfg_reg r, input logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (r)
            oapi_pkg::CFG_SLOT_COUNT: size_reg = v[6:0];
            oapi_pkg::CFG_QUAD_LIN:   c1_reg = v;
            default:                  c2_reg = v;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_res typed_res(input logic [30:0] rlkey, input logic rlused,
                                       input logic [30:0] rqkey, input logic rqused,
                                       input logic [31:0] lt, input logic [31:0] qt);
        t_res r;
        r = '0;
        r.rlkey = rlkey; r.rlused = rlused; r.rqkey = rqkey; r.rqused = rqused;
        r.ltot = lt; r.qtot = qt;
        return r;
    endfunction

    function automatic logic [30:0] rand_key();
        case ($urandom_range(0, 3))
            0: return 31'($urandom_range(0, 200));
            1: return 31'h7FFF_FFFF - 31'($urandom_range(0, 70));
            default: return 31'($urandom);
        endcase
    endfunction

    t_row dir_rows [$];

    initial begin
        t_row row;
        int phase_items;
        t_res ins_zero;
        for (int k = 0; k < DEPTH; k++) begin
            lin_used_q[k] = 1'b0; quad_used_q[k] = 1'b0;
            lin_key_q[k] = '0; quad_key_q[k] = '0;
        end
        lin_total = '0; quad_total = '0;
        size_reg = oapi_pkg::SIZE_RESET;
        c1_reg = oapi_pkg::QLIN_RESET;
        c2_reg = oapi_pkg::QSQ_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: reads of an empty table, then inserts of extreme keys with read-backs
        ins_zero = '0;
        dir_rows.push_back('{oapi_pkg::CMD_READ, 31'h0, 6'd0, 1'b1,
                             typed_res('0, 1'b0, '0, 1'b0, '0, '0)});
        dir_rows.push_back('{oapi_pkg::CMD_READ, 31'h7FFF_FFFF, 6'd63, 1'b1,
                             typed_res('0, 1'b0, '0, 1'b0, '0, '0)});
        ins_zero.lplaced = 1'b1; ins_zero.qplaced = 1'b1;
        dir_rows.push_back('{oapi_pkg::CMD_INSERT, 31'h0, 6'h3F, 1'b1, ins_zero});
        dir_rows.push_back('{oapi_pkg::CMD_READ, 31'h0, 6'd0, 1'b1,
                             typed_res('0, 1'b1, '0, 1'b1, '0, '0)});
        dir_rows.push_back('{oapi_pkg::CMD_INSERT, 31'h7FFF_FFFF, 6'd0, 1'b0, ins_zero});
        dir_rows.push_back('{oapi_pkg::CMD_INSERT, 31'h0, 6'd0, 1'b0, ins_zero});
        dir_rows.push_back('{oapi_pkg::CMD_INSERT, 31'h40, 6'd0, 1'b0, ins_zero});
        dir_rows.push_back('{oapi_pkg::CMD_INSERT, 31'h5555_5555, 6'd0, 1'b0, ins_zero});
        dir_rows.push_back('{oapi_pkg::CMD_INSERT, 31'h2AAA_AAAA, 6'd0, 1'b0, ins_zero});
        dir_rows.push_back('{oapi_pkg::CMD_READ, 31'h0, 6'd63, 1'b0, ins_zero});
        dir_rows.push_back('{oapi_pkg::CMD_READ, 31'h0, 6'd1, 1'b0, ins_zero});
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            send_word(row.cmd, row.key, row.idx, row.chk, row.res);
        end
        drain();

        // small table filled past full, size zero and size above depth
        write_reg(oapi_pkg::CFG_SLOT_COUNT, 8'd4);
        for (int k = 0; k < 7; k++) send_word(oapi_pkg::CMD_INSERT, rand_key(), '0, 1'b0, ins_zero);
        send_word(oapi_pkg::CMD_READ, '0, 6'd3, 1'b0, ins_zero);
        drain();
        write_reg(oapi_pkg::CFG_SLOT_COUNT, 8'd0);
        send_word(oapi_pkg::CMD_INSERT, 31'd9, '0, 1'b0, ins_zero);
        send_word(oapi_pkg::CMD_INSERT, 31'd9, '0, 1'b0, ins_zero);
        drain();
        write_reg(oapi_pkg::CFG_SLOT_COUNT, 8'h7F);
        write_reg(oapi_pkg::CFG_QUAD_LIN, 8'hFF);
        write_reg(oapi_pkg::CFG_QUAD_SQ, 8'hFF);
        send_word(oapi_pkg::CMD_INSERT, 31'h7FFF_FFFF, '0, 1'b0, ins_zero);
        send_word(oapi_pkg::CMD_READ, '0, 6'd63, 1'b0, ins_zero);
        drain();

        // random phases over varied sizes and coefficients
        for (int ph = 0; ph < 13; ph++) begin
            case (ph % 4)
                0: write_reg(oapi_pkg::CFG_SLOT_COUNT, 8'($urandom_range(1, 12)));
                1: write_reg(oapi_pkg::CFG_SLOT_COUNT, 8'($urandom_range(1, 64)));
                2: write_reg(oapi_pkg::CFG_SLOT_COUNT, 8'd64);
                default: write_reg(oapi_pkg::CFG_SLOT_COUNT, 8'($urandom_range(0, 127)));
            endcase
            write_reg(oapi_pkg::CFG_QUAD_LIN, (ph == 5) ? 8'd0 : 8'($urandom_range(0, 255)));
            write_reg(oapi_pkg::CFG_QUAD_SQ, (ph == 5) ? 8'd0 : 8'($urandom_range(0, 255)));
            phase_items = 50;
            for (int k = 0; k < phase_items; k++) begin
                if ($urandom_range(0, 3) == 0)
                    send_word(oapi_pkg::CMD_READ, 31'($urandom), 6'($urandom_range(0, 63)),
                              1'b0, ins_zero);
                else
                    send_word(oapi_pkg::CMD_INSERT, rand_key(), 6'($urandom_range(0, 63)),
                              1'b0, ins_zero);
                // pause until every result is back
                if (k == 25) begin
                    while (pending_res.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        $display("covered %0d results, %0d inserts, %0d of them hitting a full table",
                 n_res, n_ins, n_full);
        if (n_err == 0 && pending_res.size() == 0) begin
            $display("open_addressing_probe_insert regression: pass");
        end else begin
            $display("open_addressing_probe_insert regression: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("open_addressing_probe_insert regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
rtl/oapi_pkg.sv
rtl/oapi_div.sv
rtl/oapi_dp.sv
rtl/oapi_ctrl.sv
rtl/open_addressing_probe_insert.sv
tb/sv/tb.sv
